// File: hw/rtl/arfm_pkg.sv
// Shared types and constants for the audio ring FIFO with mono upmix.
// Holds the function codes, register indexes, command and state types.
// No dependencies.
`default_nettype none

package arfm_pkg;

    localparam int FUNC_W     = 2;
    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PULL    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS     = 2'd2;

    localparam logic [1:0] CH_MONO      = 2'd1;
    localparam logic [1:0] CH_STEREO    = 2'd2;
    localparam logic [5:0] BITS_16      = 6'd16;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUSH1,
        OP_PUSH2,
        OP_PULL,
        OP_RESTART
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WR2,
        ST_RD
    } st_t;

endpackage

`default_nettype wire

// File: hw/rtl/arfm_front.sv
// Front end: configuration registers and request classification.
// Turns each input request into a command for the queue. Uses arfm_pkg.
`default_nettype none

module arfm_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [arfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [arfm_pkg::FUNC_W-1:0]         func,
    input  wire logic signed [arfm_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic                                q_full,
    output      logic                                q_push,
    output      arfm_pkg::cmd_t                      q_cmd
);

    logic       playing_reg;
    logic [1:0] channels_reg;
    logic [5:0] bits_reg;
    logic       fmt_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg  <= 1'b0;
            channels_reg <= arfm_pkg::CH_STEREO;
            bits_reg     <= arfm_pkg::BITS_16;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                arfm_pkg::REG_PLAYING:  playing_reg  <= cfg_data[0];
                arfm_pkg::REG_CHANNELS: channels_reg <= cfg_data[1:0];
                arfm_pkg::REG_BITS:     bits_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fmt_ok = playing_reg && (bits_reg == arfm_pkg::BITS_16) &&
                    ((channels_reg == arfm_pkg::CH_MONO) ||
                     (channels_reg == arfm_pkg::CH_STEREO));

    always_comb begin
        q_cmd.sample = sample_in;
        q_cmd.op     = arfm_pkg::OP_NOP;
        unique case (func)
            arfm_pkg::FUNC_PUSH: begin
                if (fmt_ok) begin
                    q_cmd.op = (channels_reg == arfm_pkg::CH_MONO) ?
                               arfm_pkg::OP_PUSH2 : arfm_pkg::OP_PUSH1;
                end
            end
            arfm_pkg::FUNC_PULL: begin
                if (playing_reg) begin
                    q_cmd.op = arfm_pkg::OP_PULL;
                end
            end
            arfm_pkg::FUNC_RESTART: q_cmd.op = arfm_pkg::OP_RESTART;
            default:                q_cmd.op = arfm_pkg::OP_NOP;
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

// File: hw/rtl/arfm_cmd_queue.sv
// Two-entry command queue between front end and ring engine.
// Uses arfm_pkg for the command type and depth.
`default_nettype none

module arfm_cmd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire arfm_pkg::cmd_t push_cmd,
    output      logic           full,
    input  wire logic           pop,
    output      logic           valid,
    output      arfm_pkg::cmd_t head
);

    localparam int AW = arfm_pkg::CMDQ_AW;

    arfm_pkg::cmd_t entry_reg [arfm_pkg::CMDQ_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(arfm_pkg::CMDQ_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/arfm_back.sv
// Ring engine: sample memory, read/write pointers and the result register.
// Executes queued commands one at a time. Uses arfm_pkg.
`default_nettype none

module arfm_back #(
    parameter int RING_DEPTH = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_valid,
    input  wire arfm_pkg::cmd_t                    q_cmd,
    output      logic                              q_pop,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic signed [arfm_pkg::SAMPLE_W-1:0] sample_out,
    output      logic                              underrun,
    output      logic                              accepted,
    output      logic [arfm_pkg::FILL_W-1:0]       fill_level
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int USED_W = (PTR_W > arfm_pkg::FILL_W) ? PTR_W : arfm_pkg::FILL_W;
    localparam logic [PTR_W:0]   DEPTH_X = (PTR_W+1)'(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST    = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] LIMIT1  = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W-1:0] LIMIT2  = PTR_W'(RING_DEPTH - 2);

    function automatic logic [PTR_W-1:0] ring_used(input logic [PTR_W-1:0] w,
                                                   input logic [PTR_W-1:0] r);
        logic [PTR_W:0] diff;
        diff = {1'b0, w} + DEPTH_X - {1'b0, r};
        if (diff >= DEPTH_X) begin
            diff = diff - DEPTH_X;
        end
        return diff[PTR_W-1:0];
    endfunction

    logic signed [arfm_pkg::SAMPLE_W-1:0] store_reg [RING_DEPTH];
    logic signed [arfm_pkg::SAMPLE_W-1:0] rdata_reg;
    logic signed [arfm_pkg::SAMPLE_W-1:0] sample_reg;

    arfm_pkg::st_t    state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next, wp_inc;
    logic [PTR_W-1:0] rp_reg, rp_next, rp_inc;
    logic [PTR_W-1:0] used_cur;
    logic [USED_W-1:0] used_after;
    logic             room1, room2;

    logic                                 mem_we, mem_re;
    logic [PTR_W-1:0]                     mem_addr;
    logic signed [arfm_pkg::SAMPLE_W-1:0] mem_wdata;

    logic                                 load;
    logic signed [arfm_pkg::SAMPLE_W-1:0] res_sample;
    logic                                 res_underrun, res_accepted;

    logic                                 res_valid_reg;
    logic signed [arfm_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                                 res_underrun_reg, res_accepted_reg;
    logic [arfm_pkg::FILL_W-1:0]          res_fill_reg;

    assign wp_inc   = (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == LAST) ? '0 : rp_reg + 1'b1;
    assign used_cur = ring_used(wp_reg, rp_reg);
    assign room1    = (used_cur < LIMIT1);
    assign room2    = (used_cur < LIMIT2);

    assign q_pop = (state_reg == arfm_pkg::ST_IDLE) && q_valid &&
                   (!res_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            arfm_pkg::ST_IDLE: begin
                if (q_pop) begin
                    if (q_cmd.op == arfm_pkg::OP_PUSH2 && room2) begin
                        state_next = arfm_pkg::ST_WR2;
                    end else if (q_cmd.op == arfm_pkg::OP_PULL && used_cur != '0) begin
                        state_next = arfm_pkg::ST_RD;
                    end
                end
            end
            arfm_pkg::ST_WR2: state_next = arfm_pkg::ST_IDLE;
            arfm_pkg::ST_RD:  state_next = arfm_pkg::ST_IDLE;
            default:          state_next = arfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = wp_reg;
        mem_wdata    = q_cmd.sample;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        load         = 1'b0;
        res_sample   = '0;
        res_underrun = 1'b0;
        res_accepted = 1'b0;
        unique case (state_reg)
            arfm_pkg::ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_cmd.op)
                        arfm_pkg::OP_PUSH1: begin
                            load = 1'b1;
                            if (room1) begin
                                mem_we       = 1'b1;
                                wp_next      = wp_inc;
                                res_accepted = 1'b1;
                            end
                        end
                        arfm_pkg::OP_PUSH2: begin
                            if (room2) begin
                                mem_we  = 1'b1;
                                wp_next = wp_inc;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        arfm_pkg::OP_PULL: begin
                            if (used_cur == '0) begin
                                res_underrun = 1'b1;
                                load         = 1'b1;
                            end else begin
                                mem_re   = 1'b1;
                                mem_addr = rp_reg;
                                rp_next  = rp_inc;
                            end
                        end
                        arfm_pkg::OP_RESTART: begin
                            wp_next = '0;
                            rp_next = '0;
                            load    = 1'b1;
                        end
                        default: load = 1'b1;
                    endcase
                end
            end
            arfm_pkg::ST_WR2: begin
                mem_we       = 1'b1;
                mem_wdata    = sample_reg;
                wp_next      = wp_inc;
                res_accepted = 1'b1;
                load         = 1'b1;
            end
            arfm_pkg::ST_RD: begin
                res_sample = rdata_reg;
                load       = 1'b1;
            end
            default: ;
        endcase
    end

    assign used_after = USED_W'(ring_used(wp_next, rp_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= arfm_pkg::ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            if (load) begin
                res_valid_reg <= 1'b1;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sample_reg <= q_cmd.sample;
        end
        if (load) begin
            res_sample_reg   <= res_sample;
            res_underrun_reg <= res_underrun;
            res_accepted_reg <= res_accepted;
            res_fill_reg     <= used_after[arfm_pkg::FILL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_reg[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= store_reg[mem_addr];
        end
    end

    assign m_tvalid   = res_valid_reg;
    assign sample_out = res_sample_reg;
    assign underrun   = res_underrun_reg;
    assign accepted   = res_accepted_reg;
    assign fill_level = res_fill_reg;

endmodule

`default_nettype wire

// File: hw/rtl/audio_ring_fifo_mono_upmix.sv
// Top level of the audio sample ring FIFO with mono-to-stereo upmix.
// Depends on arfm_pkg, arfm_front, arfm_cmd_queue and arfm_back.
//
//   channel  dir  handshake         payload
//   s_       in   s_tvalid/tready   tdata: sample_in; tuser: func
//   m_       out  m_tvalid/tready   tdata: sample_out, fill_level; tuser: underrun, accepted
//   cfg_     in   cfg_wr_en         cfg_index, cfg_data
//
// A stored mono push takes an extra engine state, ST_WR2 (two writes on the
// single memory port), as does a pull that returns data, ST_RD (registered memory read).
// A two-entry command queue lets the input side run ahead of the engine.
// Reset clears pointers, queue and result register and loads the register
// defaults; the sample memory is not cleared. A stalled m_ side holds results
// and backs up into the queue, then s_tready.
`default_nettype none

module audio_ring_fifo_mono_upmix #(
    parameter int RING_DEPTH = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [arfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [15:0]                         s_tdata,  // [15:0] sample_in
    input  wire logic [1:0]                          s_tuser,  // [1:0] func
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [31:0]                         m_tdata,  // [15:0] sample_out, [27:16] fill_level
    output      logic [1:0]                          m_tuser   // [0] underrun, [1] accepted
);

    logic                                 q_full, q_push, q_valid, q_pop;
    arfm_pkg::cmd_t                       q_in_cmd, q_head;
    logic signed [arfm_pkg::SAMPLE_W-1:0] sample_out;
    logic                                 underrun, accepted;
    logic [arfm_pkg::FILL_W-1:0]          fill_level;

    arfm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .func      (s_tuser),
        .sample_in (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in_cmd)
    );

    arfm_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    arfm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .sample_out (sample_out),
        .underrun   (underrun),
        .accepted   (accepted),
        .fill_level (fill_level)
    );

    assign m_tdata = {4'b0000, fill_level, sample_out};
    assign m_tuser = {accepted, underrun};

    a_pop_needs_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("engine took a command from an empty queue");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(underrun && accepted))
        else $error("underrun and accepted both set");

    a_underrun_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && underrun) |-> (sample_out == '0))
        else $error("underrun result carries a nonzero sample");

    a_push_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !s_tready)
        else $error("input ready while command queue full");

endmodule

`default_nettype wire

// File: verif/arfm_reply_checker.sv
// Reply checker for audio_ring_fifo_mono_upmix: tracks config writes and accepted
// requests, predicts each reply from its own ring model and compares the m_ side.
// Depends on arfm_pkg for function codes, register indexes and format constants.
module arfm_reply_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [arfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arfm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // [15:0] sample_in
    input  logic [1:0]                      s_tuser,  // [1:0] func
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [31:0]                     m_tdata,  // [15:0] sample_out, [27:16] fill_level
    input  logic [1:0]                      m_tuser,  // [0] underrun, [1] accepted
    output int                              mismatches,
    output int                              replies_pending
);

    localparam int RING_DEPTH = 4096;

    typedef struct packed {
        logic [arfm_pkg::SAMPLE_W-1:0] sample;
        logic                          underrun;
        logic                          accepted;
        logic [arfm_pkg::FILL_W-1:0]   fill;
    } ring_reply_t;

    logic [arfm_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [arfm_pkg::FILL_W-1:0]   wr_ptr;
    logic [arfm_pkg::FILL_W-1:0]   rd_ptr;
    logic                          play_on;
    logic [1:0]                    src_ch;
    logic [5:0]                    src_bits;
    ring_reply_t                   replies_due [$];
    int                            err_count = 0;

    function automatic ring_reply_t compute_reply(logic [1:0] func,
                                                  logic [arfm_pkg::SAMPLE_W-1:0] smp);
        ring_reply_t r;
        int          held;
        int          need;
        r    = '0;
        held = int'(arfm_pkg::FILL_W'(wr_ptr - rd_ptr));
        if (func == arfm_pkg::FUNC_PUSH) begin
            if (play_on && src_bits == arfm_pkg::BITS_16 &&
                (src_ch == arfm_pkg::CH_MONO || src_ch == arfm_pkg::CH_STEREO)) begin
                need = (src_ch == arfm_pkg::CH_MONO) ? 2 : 1;
                if (RING_DEPTH - 1 - held >= need) begin
                    repeat (need) begin
                        ring_mem[wr_ptr] = smp;
                        wr_ptr = wr_ptr + 1'b1;
                    end
                    r.accepted = 1'b1;
                end
            end
        end else if (func == arfm_pkg::FUNC_PULL) begin
            if (play_on) begin
                if (held == 0) begin
                    r.underrun = 1'b1;
                end else begin
                    r.sample = ring_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                end
            end
        end else if (func == arfm_pkg::FUNC_RESTART) begin
            wr_ptr = '0;
            rd_ptr = '0;
        end
        r.fill = wr_ptr - rd_ptr;
        return r;
    endfunction

    function automatic int field_bad(string name, int want, int got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        ring_reply_t want;
        int          bad;
        if (!aresetn) begin
            wr_ptr   = '0;
            rd_ptr   = '0;
            play_on  = 1'b0;
            src_ch   = arfm_pkg::CH_STEREO;
            src_bits = arfm_pkg::BITS_16;
            replies_due.delete();
        end else begin
            // replies first: the block cannot answer a request in its own cycle
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply expected none actual %h/%h", $time, m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = replies_due.pop_front();
                    bad  = field_bad("sample_out", want.sample, m_tdata[15:0]);
                    bad += field_bad("fill_level", want.fill, m_tdata[27:16]);
                    bad += field_bad("underrun", want.underrun, m_tuser[0]);
                    bad += field_bad("accepted", want.accepted, m_tuser[1]);
                    if (bad != 0) err_count++;
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    arfm_pkg::REG_PLAYING:  play_on  = cfg_data[0];
                    arfm_pkg::REG_CHANNELS: src_ch   = cfg_data[1:0];
                    arfm_pkg::REG_BITS:     src_bits = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                replies_due.push_back(compute_reply(s_tuser, s_tdata));
        end
        mismatches      <= err_count;
        replies_pending <= replies_due.size();
    end

endmodule

// File: verif/tb_audio_ring_fifo_mono_upmix.sv
// Top of the audio_ring_fifo_mono_upmix testbench: clock, reset, request and
// config stimulus, randomized m_tready, verdict. Depends on arfm_pkg, the block
// and arfm_reply_checker, which predicts and compares every reply.
module tb_audio_ring_fifo_mono_upmix;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1000;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [arfm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [arfm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;
    logic [1:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [31:0]                     m_tdata;
    logic [1:0]                      m_tuser;
    int                              mismatches;
    int                              replies_pending;
    logic                            no_idle   = 1'b0;
    int                              rx_wait   = 0;
    int                              cycles    = 0;

    always #5 aclk = ~aclk;

    audio_ring_fifo_mono_upmix DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    arfm_reply_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .mismatches(mismatches), .replies_pending(replies_pending)
    );

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin : rx_side
        int g;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tready && m_tvalid) begin
            g = draw_gap();
            m_tready <= (g == 0);
            rx_wait  <= g;
        end else if (!m_tready) begin
            if (rx_wait <= 1) m_tready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    // valid stays high across back-to-back requests
    task automatic send_request(input logic [1:0] func, input logic [15:0] smp);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic play, input logic [1:0] ch,
                                input logic [5:0] nbits);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= arfm_pkg::REG_PLAYING;
        cfg_data  <= {5'd0, play};
        @(posedge aclk);
        cfg_index <= arfm_pkg::REG_CHANNELS;
        cfg_data  <= {4'd0, ch};
        @(posedge aclk);
        cfg_index <= arfm_pkg::REG_BITS;
        cfg_data  <= nbits;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        int          random_sent;
        int          n;
        int          r;
        logic        play;
        logic [1:0]  ch;
        logic [5:0]  nbits;
        logic [1:0]  func;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // playback off after reset: silent pull, ignored push
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);
        send_request(arfm_pkg::FUNC_PUSH, 16'h1234);

        write_config(1'b1, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PULL, 16'hFFFF);
        send_request(arfm_pkg::FUNC_PUSH, 16'h7FFF);
        send_request(arfm_pkg::FUNC_PUSH, 16'h8000);
        send_request(arfm_pkg::FUNC_PUSH, 16'h0000);
        send_request(arfm_pkg::FUNC_PUSH, 16'hFFFF);
        send_request(FUNC_SPARE, 16'hA5A5);
        repeat (5) send_request(arfm_pkg::FUNC_PULL, 16'h0000);

        write_config(1'b1, arfm_pkg::CH_MONO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PUSH, 16'h8000);
        send_request(arfm_pkg::FUNC_PUSH, 16'h7FFF);
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);
        send_request(arfm_pkg::FUNC_RESTART, 16'h0000);
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);

        // unsupported formats
        write_config(1'b1, arfm_pkg::CH_MONO, 6'd32);
        send_request(arfm_pkg::FUNC_PUSH, 16'h1111);
        write_config(1'b1, arfm_pkg::CH_STEREO, 6'd0);
        send_request(arfm_pkg::FUNC_PUSH, 16'h2222);
        write_config(1'b1, arfm_pkg::CH_STEREO, 6'd63);
        send_request(arfm_pkg::FUNC_PUSH, 16'h3333);
        write_config(1'b1, 2'd0, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PUSH, 16'h4444);
        write_config(1'b1, 2'd3, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PUSH, 16'h5555);

        // restart with playback off still empties the ring
        write_config(1'b1, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PUSH, 16'h6666);
        write_config(1'b0, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_RESTART, 16'h0000);
        write_config(1'b1, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);

        // fill to full with mono pairs, top off in stereo, wrap the write side,
        // then restart and pull from the empty ring
        write_config(1'b1, arfm_pkg::CH_MONO, arfm_pkg::BITS_16);
        send_request(arfm_pkg::FUNC_RESTART, 16'h0000);
        repeat (2048) send_request(arfm_pkg::FUNC_PUSH, 16'($urandom));
        write_config(1'b1, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        repeat (2) send_request(arfm_pkg::FUNC_PUSH, 16'($urandom));
        send_request(FUNC_SPARE, 16'($urandom));
        repeat (3) send_request(arfm_pkg::FUNC_PULL, 16'($urandom));
        write_config(1'b1, arfm_pkg::CH_MONO, arfm_pkg::BITS_16);
        repeat (2) send_request(arfm_pkg::FUNC_PUSH, 16'($urandom));
        write_config(1'b1, arfm_pkg::CH_STEREO, arfm_pkg::BITS_16);
        repeat (2) send_request(arfm_pkg::FUNC_PUSH, 16'($urandom));
        repeat (4) send_request(arfm_pkg::FUNC_PULL, 16'($urandom));
        send_request(arfm_pkg::FUNC_RESTART, 16'h0000);
        send_request(arfm_pkg::FUNC_PULL, 16'h0000);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                play  = 1'b1;
                ch    = $urandom_range(0, 1) ? arfm_pkg::CH_MONO : arfm_pkg::CH_STEREO;
                nbits = arfm_pkg::BITS_16;
            end else begin
                play  = 1'($urandom_range(0, 1));
                ch    = 2'($urandom_range(0, 3));
                nbits = $urandom_range(0, 1) ? arfm_pkg::BITS_16 : 6'($urandom_range(0, 63));
            end
            write_config(play, ch, nbits);
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 48)      func = arfm_pkg::FUNC_PUSH;
                else if (r < 90) func = arfm_pkg::FUNC_PULL;
                else if (r < 95) func = arfm_pkg::FUNC_RESTART;
                else             func = FUNC_SPARE;
                send_request(func, 16'($urandom));
                if ($urandom_range(0, 49) == 0) wait_idle();
            end
            random_sent += n;
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
